>>> hw/rtl/ucd_pkg.sv
`timescale 1ns / 1ps

package ucd_pkg;

  localparam int CountWidthDef = 16;
  localparam int OutCountWidth = 16;
  localparam int WinDepth      = 8;
  localparam int FillWidth     = $clog2(WinDepth + 1);
  localparam int WinIdxWidth   = $clog2(WinDepth);

  localparam logic [7:0] GbLeadMin  = 8'd161;
  localparam logic [7:0] GbLeadMax  = 8'd247;
  localparam logic [7:0] GbTrailMin = 8'd161;
  localparam logic [7:0] GbTrailMax = 8'd254;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } ucd_state_e;

  typedef struct packed {
    logic load;   // take one byte into both scanners
    logic step;   // resolve the window head
    logic clear;  // back to reset state after the verdict
  } ucd_cmd_t;

  typedef struct packed {
    logic scan_busy;  // window head can be resolved now
  } ucd_status_t;

  function automatic logic [FillWidth-1:0] lead_ones(input logic [7:0] b);
    logic [FillWidth-1:0] n;
    logic                 run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + FillWidth'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/utf8_gb2312_charset_detector_top.sv
`timescale 1ns / 1ps

// Guesses whether a byte string is UTF-8 or GB2312. Bytes stream in one
// request at a time, with tuser marking a real byte and tlast closing the
// string; the closing request yields one verdict request carrying both byte
// counts, after which all state returns to reset. A byte is accepted, then
// the window logic resolves window heads until the window is found settled,
// and only then is the next request taken; while scanning it resolves one
// head per cycle in an eight-byte buffer. A request without a byte and
// without tlast changes nothing. The verdict is held until taken, and no
// byte is accepted meanwhile.
module utf8_gb2312_charset_detector_top
  import ucd_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] gb_bytes, [31:16] utf8_bytes
  output logic        m_axis_tuser    // [0] is_utf8
);

  ucd_cmd_t                 cmd;
  ucd_status_t              status;
  logic [OutCountWidth-1:0] gb_bytes;
  logic [OutCountWidth-1:0] utf8_bytes;

  ucd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_has_i    (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ucd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .byte_i       (s_axis_tdata),
    .status_o     (status),
    .is_utf8_o    (m_axis_tuser),
    .gb_bytes_o   (gb_bytes),
    .utf8_bytes_o (utf8_bytes)
  );

  assign m_axis_tdata = {utf8_bytes, gb_bytes};

endmodule

>>> hw/rtl/ucd_ctrl.sv
`timescale 1ns / 1ps

module ucd_ctrl
  import ucd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_has_i,
  input  logic        in_last_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ucd_status_t status_i,
  output ucd_cmd_t    cmd_o
);

  ucd_state_e state_q, state_d;
  logic       last_q, last_d;
  logic       in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d = in_last_i;
          if (in_has_i) begin
            state_d = ST_SCAN;
          end else if (in_last_i) begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        if (!status_i.scan_busy) begin
          state_d = last_q ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
          last_d  = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_acc && in_has_i;
      end
      ST_SCAN: begin
        cmd_o.step = status_i.scan_busy;
      end
      ST_RESULT: begin
        out_valid_o = 1'b1;
        cmd_o.clear = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

endmodule

>>> hw/rtl/ucd_datapath.sv
`timescale 1ns / 1ps

module ucd_datapath
  import ucd_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ucd_cmd_t                 cmd_i,
  input  logic [7:0]               byte_i,
  output ucd_status_t              status_o,
  output logic                     is_utf8_o,
  output logic [OutCountWidth-1:0] gb_bytes_o,
  output logic [OutCountWidth-1:0] utf8_bytes_o
);

  logic [COUNT_WIDTH-1:0] gb_q, gb_d;
  logic [COUNT_WIDTH-1:0] utf_q, utf_d;
  logic                   pend_q, pend_d;
  logic [FillWidth-1:0]   fill_q, fill_d;
  logic [7:0]             win_q [WinDepth];
  logic [7:0]             win_d [WinDepth];

  logic [FillWidth-1:0]   head_n;
  logic                   tails_ok;
  logic [FillWidth-1:0]   drop_k;
  logic [COUNT_WIDTH:0]   gb_sum;
  logic [COUNT_WIDTH:0]   utf_sum;
  logic                   is_trail;
  logic                   is_lead;

  assign head_n   = lead_ones(win_q[0]);
  assign is_trail = (byte_i >= GbTrailMin) && (byte_i <= GbTrailMax);
  assign is_lead  = (byte_i >= GbLeadMin) && (byte_i <= GbLeadMax);

  assign status_o.scan_busy = (fill_q != '0) &&
                              ((head_n < FillWidth'(2)) || (fill_q >= head_n));

  always_comb begin
    tails_ok = 1'b1;
    for (int j = 1; j < WinDepth; j++) begin
      if ((FillWidth'(j) < head_n) && !win_q[j][7]) begin
        tails_ok = 1'b0;
      end
    end
  end

  assign gb_sum  = {1'b0, gb_q} + (COUNT_WIDTH + 1)'(2);
  assign utf_sum = {1'b0, utf_q} + (COUNT_WIDTH + 1)'(head_n);

  always_comb begin
    gb_d   = gb_q;
    utf_d  = utf_q;
    pend_d = pend_q;
    fill_d = fill_q;
    win_d  = win_q;
    drop_k = FillWidth'(1);
    if (cmd_i.clear) begin
      gb_d   = '0;
      utf_d  = '0;
      pend_d = 1'b0;
      fill_d = '0;
    end else if (cmd_i.load) begin
      if (pend_q && is_trail) begin
        gb_d   = gb_sum[COUNT_WIDTH] ? '1 : gb_sum[COUNT_WIDTH-1:0];
        pend_d = 1'b0;
      end else begin
        pend_d = is_lead;
      end
      // fill never exceeds WinDepth-1 between bytes
      win_d[fill_q[WinIdxWidth-1:0]] = byte_i;
      fill_d = fill_q + FillWidth'(1);
    end else if (cmd_i.step) begin
      if (head_n >= FillWidth'(2) && tails_ok) begin
        drop_k = head_n;
        utf_d  = utf_sum[COUNT_WIDTH] ? '1 : utf_sum[COUNT_WIDTH-1:0];
      end
      for (int i = 0; i < WinDepth; i++) begin
        if ((i + int'(drop_k)) < WinDepth) begin
          win_d[i] = win_q[WinIdxWidth'(i + int'(drop_k))];
        end
      end
      fill_d = (drop_k >= fill_q) ? '0 : fill_q - drop_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q   <= '0;
      utf_q  <= '0;
      pend_q <= 1'b0;
      fill_q <= '0;
    end else begin
      gb_q   <= gb_d;
      utf_q  <= utf_d;
      pend_q <= pend_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign is_utf8_o = utf_q > gb_q;

  if (COUNT_WIDTH >= OutCountWidth) begin : g_trunc
    assign gb_bytes_o   = gb_q[OutCountWidth-1:0];
    assign utf8_bytes_o = utf_q[OutCountWidth-1:0];
  end else begin : g_ext
    assign gb_bytes_o   = {{(OutCountWidth - COUNT_WIDTH){1'b0}}, gb_q};
    assign utf8_bytes_o = {{(OutCountWidth - COUNT_WIDTH){1'b0}}, utf_q};
  end

endmodule
